// ----- design/ach_pkg.sv -----
// shared types, codes and constants for the connection handshake initiator
// no dependencies
`timescale 1ns / 1ps

package ach_pkg;

   localparam int SEQ_BITS  = 16;
   localparam int TIME_BITS = 32;
   localparam int MUX_BITS  = 16;
   localparam int TRY_BITS  = 8;
   localparam int OP_BITS   = 3;
   localparam int STAGE_BITS = 3;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   // request op codes
   localparam logic [OP_BITS-1:0] OP_START    = 3'd0;
   localparam logic [OP_BITS-1:0] OP_POLL     = 3'd1;
   localparam logic [OP_BITS-1:0] OP_REFUSED  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_RETRY    = 3'd3;
   localparam logic [OP_BITS-1:0] OP_PEER_ACK = 3'd4;
   localparam logic [OP_BITS-1:0] OP_DATAGRAM = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RETRY_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_TRIES     = 2'd2;

   localparam logic [TIME_BITS-1:0] TOTAL_TIMEOUT_RESET = 32'd10000;
   localparam logic [TIME_BITS-1:0] RETRY_TIMEOUT_RESET = 32'd1000;
   localparam logic [TRY_BITS-1:0]  MAX_TRIES_RESET     = 8'd5;

   localparam logic [SEQ_BITS-1:0] SEQ_STEP = 16'd3;
   localparam logic [TRY_BITS-1:0] TRY_MAX  = 8'hFF;
   localparam logic [TRY_BITS-1:0] TRY_ONE  = 8'd1;

   // stage codes as seen on the result channel
   localparam logic [STAGE_BITS-1:0] STAGE_IDLE     = 3'd0;
   localparam logic [STAGE_BITS-1:0] STAGE_START    = 3'd1;
   localparam logic [STAGE_BITS-1:0] STAGE_WAIT     = 3'd2;
   localparam logic [STAGE_BITS-1:0] STAGE_DONE     = 3'd3;
   localparam logic [STAGE_BITS-1:0] STAGE_FAILED   = 3'd4;
   localparam logic [STAGE_BITS-1:0] STAGE_FINISHED = 3'd5;

   localparam logic SEND_INIT = 1'b0;
   localparam logic SEND_ACK  = 1'b1;

   // request class, one-hot
   typedef enum logic [6:0] {
      CLS_START    = 7'b0000001,
      CLS_POLL     = 7'b0000010,
      CLS_REFUSED  = 7'b0000100,
      CLS_RETRY    = 7'b0001000,
      CLS_PEER_ACK = 7'b0010000,
      CLS_DATAGRAM = 7'b0100000,
      CLS_NONE     = 7'b1000000
   } op_class_type;

   // handshake state machine, one-hot
   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_START    = 6'b000010,
      ST_WAIT     = 6'b000100,
      ST_DONE     = 6'b001000,
      ST_FAILED   = 6'b010000,
      ST_FINISHED = 6'b100000
   } hs_state_type;

   // classified request as held in the queue
   typedef struct packed {
      op_class_type          cls;
      logic [TIME_BITS-1:0]  now;
      logic [SEQ_BITS-1:0]   seq;
      logic [MUX_BITS-1:0]   mux;
      logic                  mux_zero;
      logic [TIME_BITS-1:0]  total_dl;
      logic [TIME_BITS-1:0]  retry_dl;
   } hs_item_type;

   // queue status toward the back end
   typedef struct packed {
      logic avail;
      logic full;
   } q_status_type;

   function automatic logic [STAGE_BITS-1:0] stage_code(hs_state_type st);
      logic [STAGE_BITS-1:0] code;
      case (st)
         ST_IDLE:     code = STAGE_IDLE;
         ST_START:    code = STAGE_START;
         ST_WAIT:     code = STAGE_WAIT;
         ST_DONE:     code = STAGE_DONE;
         ST_FAILED:   code = STAGE_FAILED;
         ST_FINISHED: code = STAGE_FINISHED;
         default:     code = STAGE_IDLE;
      endcase
      return code;
   endfunction

   // now plus timeout, pinned at the top of the time range
   function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] a,
                                                   logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   endfunction

endpackage

// ----- design/ach_front.sv -----
// front end: decodes the request op and precomputes both candidate deadlines
// depends on ach_pkg
`timescale 1ns / 1ps

module ach_front import ach_pkg::*; (
   input  logic [OP_BITS-1:0]   req_op,
   input  logic [TIME_BITS-1:0] req_now,
   input  logic [SEQ_BITS-1:0]  req_seq_idx,
   input  logic [MUX_BITS-1:0]  req_new_local_mux,
   input  logic [TIME_BITS-1:0] total_timeout,
   input  logic [TIME_BITS-1:0] retry_timeout,
   output hs_item_type          item
);

   op_class_type cls;

   always_comb begin
      case (req_op)
         OP_START:    cls = CLS_START;
         OP_POLL:     cls = CLS_POLL;
         OP_REFUSED:  cls = CLS_REFUSED;
         OP_RETRY:    cls = CLS_RETRY;
         OP_PEER_ACK: cls = CLS_PEER_ACK;
         OP_DATAGRAM: cls = CLS_DATAGRAM;
         default:     cls = CLS_NONE;
      endcase
   end

   // user holds config stable while requests are in flight, so deadlines form here
   always_comb begin
      item.cls      = cls;
      item.now      = req_now;
      item.seq      = req_seq_idx;
      item.mux      = req_new_local_mux;
      item.mux_zero = (req_new_local_mux == '0);
      item.total_dl = sat_add(req_now, total_timeout);
      item.retry_dl = sat_add(req_now, retry_timeout);
   end

endmodule

// ----- design/ach_queue.sv -----
// short queue of classified requests between front and back end
// depends on ach_pkg
`timescale 1ns / 1ps

module ach_queue import ach_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  hs_item_type  push_item,
   input  logic         pop,
   output q_status_type status,
   output hs_item_type  head_item
);

   hs_item_type             slot_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]   count_ff, count_in;

   function automatic logic [Q_PTR_BITS-1:0] ptr_next(logic [Q_PTR_BITS-1:0] p);
      return (p == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign status.avail = (count_ff != '0);
   assign status.full  = (count_ff == Q_CNT_BITS'(Q_DEPTH));
   assign head_item    = slot_ff[rd_ptr_ff];

endmodule

// ----- design/ach_back.sv -----
// back end: handshake state machine and registered result stage
// depends on ach_pkg
`timescale 1ns / 1ps

module ach_back import ach_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  q_status_type          q_status,
   input  hs_item_type           item,
   output logic                  pop,
   input  logic [TRY_BITS-1:0]   max_tries,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_send_valid,
   output logic                  rsp_send_kind,
   output logic [SEQ_BITS-1:0]   rsp_send_seq,
   output logic [MUX_BITS-1:0]   rsp_local_mux,
   output logic [STAGE_BITS-1:0] rsp_stage_now,
   output logic                  rsp_completed_pulse,
   output logic                  rsp_failed_pulse,
   output logic                  rsp_alive
);

   hs_state_type          state_ff, state_in;
   logic [SEQ_BITS-1:0]   sequence_ff, sequence_in;
   logic [TIME_BITS-1:0]  total_dl_ff, total_dl_in;
   logic [TIME_BITS-1:0]  retry_dl_ff, retry_dl_in;
   logic [TRY_BITS-1:0]   try_ff, try_in;
   logic [MUX_BITS-1:0]   mux_ff, mux_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  send_ff, send_in;
   logic                  kind_ff, kind_in;
   logic [SEQ_BITS-1:0]   sseq_ff, sseq_in;
   logic                  done_ff, done_in;
   logic                  fail_ff, fail_in;
   logic [MUX_BITS-1:0]   omux_ff;
   hs_state_type          ostate_ff;

   logic                  active;
   logic                  seq_match;

   assign pop       = q_status.avail && (!out_valid_ff || !rsp_stall);
   assign active    = (state_ff == ST_START) || (state_ff == ST_WAIT) ||
                      (state_ff == ST_DONE);
   assign seq_match = (item.seq == sequence_ff);

   always_comb begin
      state_in    = state_ff;
      sequence_in = sequence_ff;
      total_dl_in = total_dl_ff;
      retry_dl_in = retry_dl_ff;
      try_in      = try_ff;
      mux_in      = mux_ff;
      send_in     = 1'b0;
      kind_in     = SEND_INIT;
      sseq_in     = '0;
      done_in     = 1'b0;
      fail_in     = 1'b0;

      if (pop) begin
         case (item.cls)
            CLS_START: begin
               sequence_in = item.seq;
               mux_in      = item.mux;
               total_dl_in = item.total_dl;
               retry_dl_in = item.now;
               try_in      = TRY_ONE;
               state_in    = ST_START;
            end
            CLS_POLL: begin
               if (active) begin
                  if (item.now > total_dl_ff) begin
                     if (state_ff == ST_DONE) begin
                        state_in = ST_FINISHED;
                     end else begin
                        state_in = ST_FAILED;
                        fail_in  = 1'b1;
                     end
                  end else if (state_ff == ST_START) begin
                     state_in    = ST_WAIT;
                     send_in     = 1'b1;
                     kind_in     = SEND_INIT;
                     sseq_in     = sequence_ff;
                     retry_dl_in = item.retry_dl;
                  end else if (state_ff == ST_WAIT && item.now > retry_dl_ff) begin
                     // retry timer ran out
                     if (try_ff > max_tries) begin
                        state_in = ST_FAILED;
                        fail_in  = 1'b1;
                     end else begin
                        try_in      = (try_ff != TRY_MAX) ? try_ff + 1'b1 : try_ff;
                        sequence_in = sequence_ff + SEQ_STEP;
                        state_in    = ST_START;
                     end
                  end
               end
            end
            CLS_REFUSED: begin
               if (state_ff == ST_WAIT && seq_match) begin
                  state_in = ST_FAILED;
                  fail_in  = 1'b1;
               end
            end
            CLS_RETRY: begin
               if (state_ff == ST_WAIT && seq_match) begin
                  if (item.mux_zero) begin
                     state_in = ST_FAILED;
                     fail_in  = 1'b1;
                  end else begin
                     mux_in = item.mux;
                     if (try_ff > max_tries) begin
                        state_in = ST_FAILED;
                        fail_in  = 1'b1;
                     end else begin
                        try_in      = (try_ff != TRY_MAX) ? try_ff + 1'b1 : try_ff;
                        sequence_in = sequence_ff + SEQ_STEP;
                        state_in    = ST_START;
                     end
                  end
               end
            end
            CLS_PEER_ACK: begin
               if ((state_ff == ST_WAIT || state_ff == ST_DONE) &&
                   item.seq >= sequence_ff) begin
                  send_in = 1'b1;
                  kind_in = SEND_ACK;
                  sseq_in = sequence_ff;
                  if (state_ff == ST_WAIT) begin
                     state_in = ST_DONE;
                     done_in  = 1'b1;
                  end
               end
            end
            CLS_DATAGRAM: begin
               if (active) begin
                  state_in = ST_FINISHED;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sequence_ff  <= '0;
         total_dl_ff  <= '0;
         retry_dl_ff  <= '0;
         try_ff       <= TRY_ONE;
         mux_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sequence_ff  <= sequence_in;
         total_dl_ff  <= total_dl_in;
         retry_dl_ff  <= retry_dl_in;
         try_ff       <= try_in;
         mux_ff       <= mux_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload, loaded with each executed request
   always_ff @(posedge clock) begin
      if (pop) begin
         send_ff   <= send_in;
         kind_ff   <= kind_in;
         sseq_ff   <= sseq_in;
         done_ff   <= done_in;
         fail_ff   <= fail_in;
         omux_ff   <= mux_in;
         ostate_ff <= state_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_send_valid      = send_ff;
   assign rsp_send_kind       = kind_ff;
   assign rsp_send_seq        = sseq_ff;
   assign rsp_local_mux       = omux_ff;
   assign rsp_stage_now       = stage_code(ostate_ff);
   assign rsp_completed_pulse = done_ff;
   assign rsp_failed_pulse    = fail_ff;
   assign rsp_alive           = (ostate_ff != ST_FAILED) && (ostate_ff != ST_FINISHED);

endmodule

// ----- design/active_connection_handshake_top.sv -----
// top level of the connection handshake initiator: config registers, front, queue, back
// depends on ach_pkg, ach_front, ach_queue, ach_back
`timescale 1ns / 1ps

// Initiator side of a three-way connection handshake with retry. Each request
// (start, poll tick, refused, retry request, peer ack, any datagram) produces
// exactly one response carrying the packet to send, if any, the current local
// mux, the stage after the request and the completed/failed pulses. One
// request is taken per clock while req_stall is low; a response is presented
// once its request has left the queue and been loaded into the back end's
// output register. The front end decodes the op and forms both saturating
// deadlines, a two-entry queue decouples it from the back end, and the back
// end runs the state machine (compares, sequence step, try count) and holds
// the response in an output register, so a new request is taken while an
// earlier response waits. req_stall rises only when the queue holds two
// requests, i.e. after the response side stalls. Timeout and try-limit
// registers are to be written by the user through the csr port while no
// request is in flight; the block itself does not enforce this.
module active_connection_handshake_top import ach_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_BITS-1:0]       req_op,
   input  logic [TIME_BITS-1:0]     req_now,
   input  logic [SEQ_BITS-1:0]      req_seq_idx,
   input  logic [MUX_BITS-1:0]      req_new_local_mux,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_send_valid,
   output logic                     rsp_send_kind,
   output logic [SEQ_BITS-1:0]      rsp_send_seq,
   output logic [MUX_BITS-1:0]      rsp_local_mux,
   output logic [STAGE_BITS-1:0]    rsp_stage_now,
   output logic                     rsp_completed_pulse,
   output logic                     rsp_failed_pulse,
   output logic                     rsp_alive,
   // configuration writes
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic [TIME_BITS-1:0] total_timeout_ff, total_timeout_in;
   logic [TIME_BITS-1:0] retry_timeout_ff, retry_timeout_in;
   logic [TRY_BITS-1:0]  max_tries_ff, max_tries_in;

   hs_item_type  front_item;
   hs_item_type  head_item;
   q_status_type q_status;
   logic         q_push;
   logic         q_pop;

   // config registers; an index past the list is dropped
   always_comb begin
      total_timeout_in = total_timeout_ff;
      retry_timeout_in = retry_timeout_ff;
      max_tries_in     = max_tries_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_TOTAL_TIMEOUT: total_timeout_in = csr_wdata[TIME_BITS-1:0];
            CSR_RETRY_TIMEOUT: retry_timeout_in = csr_wdata[TIME_BITS-1:0];
            CSR_MAX_TRIES:     max_tries_in     = csr_wdata[TRY_BITS-1:0];
            default:           max_tries_in     = max_tries_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_timeout_ff <= TOTAL_TIMEOUT_RESET;
         retry_timeout_ff <= RETRY_TIMEOUT_RESET;
         max_tries_ff     <= MAX_TRIES_RESET;
      end else begin
         total_timeout_ff <= total_timeout_in;
         retry_timeout_ff <= retry_timeout_in;
         max_tries_ff     <= max_tries_in;
      end
   end

   // front end: classify and form deadlines
   ach_front u_front (
      .req_op            (req_op),
      .req_now           (req_now),
      .req_seq_idx       (req_seq_idx),
      .req_new_local_mux (req_new_local_mux),
      .total_timeout     (total_timeout_ff),
      .retry_timeout     (retry_timeout_ff),
      .item              (front_item)
   );

   // stall depends only on queue occupancy, never on req_valid
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   ach_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .status    (q_status),
      .head_item (head_item)
   );

   // back end: state machine plus response register
   ach_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .item                (head_item),
      .pop                 (q_pop),
      .max_tries           (max_tries_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_send_valid      (rsp_send_valid),
      .rsp_send_kind       (rsp_send_kind),
      .rsp_send_seq        (rsp_send_seq),
      .rsp_local_mux       (rsp_local_mux),
      .rsp_stage_now       (rsp_stage_now),
      .rsp_completed_pulse (rsp_completed_pulse),
      .rsp_failed_pulse    (rsp_failed_pulse),
      .rsp_alive           (rsp_alive)
   );

`ifndef SYNTHESIS
   // a completion report always leaves the handshake completed, with an ack sent
   a_completed_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_completed_pulse |->
         rsp_stage_now == STAGE_DONE && rsp_send_valid && rsp_send_kind == SEND_ACK)
      else $error("completed pulse without completed stage and ack");

   // a failure report leaves the handshake failed and dead
   a_failed_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed_pulse |-> rsp_stage_now == STAGE_FAILED && !rsp_alive)
      else $error("failed pulse without failed stage");

   // an init packet only goes out as the handshake enters waiting
   a_init_waits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_valid && rsp_send_kind == SEND_INIT |->
         rsp_stage_now == STAGE_WAIT && !rsp_completed_pulse && !rsp_failed_pulse)
      else $error("init sent outside waiting stage");
`endif

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for active_connection_handshake_top: directed and random requests
// depends on ach_pkg and the design sources under design/
`timescale 1ns / 1ps

module testbench;
   import ach_pkg::*;

   // op codes the block must ignore
   localparam logic [OP_BITS-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [OP_BITS-1:0] OP_UNUSED_7 = 3'd7;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 6;

   // one response as seen on the rsp_ ports
   typedef struct packed {
      logic                  send_valid;
      logic                  send_kind;
      logic [SEQ_BITS-1:0]   send_seq;
      logic [MUX_BITS-1:0]   local_mux;
      logic [STAGE_BITS-1:0] stage_now;
      logic                  completed_pulse;
      logic                  failed_pulse;
      logic                  alive;
   } hs_response_type;

   // tracks the initiator state, predicts each response and checks it in order
   class handshake_tracker;
      logic [TIME_BITS-1:0]  total_span;
      logic [TIME_BITS-1:0]  retry_span;
      logic [TRY_BITS-1:0]   try_limit;
      logic [STAGE_BITS-1:0] cur_stage;
      logic [SEQ_BITS-1:0]   cur_seq;
      logic [TIME_BITS-1:0]  total_dl;
      logic [TIME_BITS-1:0]  retry_dl;
      logic [TRY_BITS-1:0]   tries;
      logic [MUX_BITS-1:0]   cur_mux;
      hs_response_type       expected_responses[$];
      int                    errors;

      function new();
         total_span = 32'd10000;
         retry_span = 32'd1000;
         try_limit  = 8'd5;
         cur_stage  = STAGE_IDLE;
         cur_seq    = '0;
         total_dl   = '0;
         retry_dl   = '0;
         tries      = 8'd1;
         cur_mux    = '0;
         errors     = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_TOTAL_TIMEOUT: total_span = data;
            CSR_RETRY_TIMEOUT: retry_span = data;
            CSR_MAX_TRIES:     try_limit  = data[TRY_BITS-1:0];
            default: ;
         endcase
      endfunction

      // deadline pinned at the top of the time range
      function logic [TIME_BITS-1:0] deadline_after(logic [TIME_BITS-1:0] base,
                                                    logic [TIME_BITS-1:0] span);
         logic [TIME_BITS:0] total;
         total = {1'b0, base} + {1'b0, span};
         if (total[TIME_BITS])
            return '1;
         return total[TIME_BITS-1:0];
      endfunction

      // returns 1 when the try limit is exceeded and the handshake fails
      function logic retry_or_fail();
         if (tries > try_limit) begin
            cur_stage = STAGE_FAILED;
            return 1'b1;
         end
         if (tries != 8'hFF)
            tries = tries + 8'd1;
         cur_seq   = cur_seq + 16'd3;
         cur_stage = STAGE_START;
         return 1'b0;
      endfunction

      function void note_request(logic [OP_BITS-1:0] op, logic [TIME_BITS-1:0] now,
                                 logic [SEQ_BITS-1:0] seq, logic [MUX_BITS-1:0] mux);
         hs_response_type r;
         logic            active;
         r = '0;
         active = cur_stage != STAGE_IDLE && cur_stage != STAGE_FAILED &&
                  cur_stage != STAGE_FINISHED;
         if (op == OP_START) begin
            cur_seq   = seq;
            cur_mux   = mux;
            total_dl  = deadline_after(now, total_span);
            retry_dl  = now;
            tries     = 8'd1;
            cur_stage = STAGE_START;
         end else if (active) begin
            case (op)
               OP_POLL: begin
                  if (now > total_dl) begin
                     if (cur_stage == STAGE_DONE)
                        cur_stage = STAGE_FINISHED;
                     else begin
                        cur_stage      = STAGE_FAILED;
                        r.failed_pulse = 1'b1;
                     end
                  end else if (cur_stage == STAGE_START) begin
                     cur_stage    = STAGE_WAIT;
                     r.send_valid = 1'b1;
                     r.send_kind  = SEND_INIT;
                     r.send_seq   = cur_seq;
                     retry_dl     = deadline_after(now, retry_span);
                  end else if (cur_stage == STAGE_WAIT && now > retry_dl)
                     r.failed_pulse = retry_or_fail();
               end
               OP_REFUSED: begin
                  if (seq == cur_seq && cur_stage == STAGE_WAIT) begin
                     cur_stage      = STAGE_FAILED;
                     r.failed_pulse = 1'b1;
                  end
               end
               OP_RETRY: begin
                  if (seq == cur_seq && cur_stage == STAGE_WAIT) begin
                     if (mux == '0) begin
                        cur_stage      = STAGE_FAILED;
                        r.failed_pulse = 1'b1;
                     end else begin
                        cur_mux        = mux;
                        r.failed_pulse = retry_or_fail();
                     end
                  end
               end
               OP_PEER_ACK: begin
                  if (seq >= cur_seq &&
                      (cur_stage == STAGE_WAIT || cur_stage == STAGE_DONE)) begin
                     r.send_valid = 1'b1;
                     r.send_kind  = SEND_ACK;
                     r.send_seq   = cur_seq;
                     if (cur_stage == STAGE_WAIT) begin
                        cur_stage         = STAGE_DONE;
                        r.completed_pulse = 1'b1;
                     end
                  end
               end
               OP_DATAGRAM: cur_stage = STAGE_FINISHED;
               default: ;
            endcase
         end
         r.local_mux = cur_mux;
         r.stage_now = cur_stage;
         r.alive     = cur_stage != STAGE_FAILED && cur_stage != STAGE_FINISHED;
         expected_responses = {expected_responses, r};
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_response(hs_response_type got);
         hs_response_type want;
         if (expected_responses.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, actual %0h", $time, got);
            return;
         end
         want = expected_responses.pop_front();
         compare("send_valid", 32'(want.send_valid), 32'(got.send_valid));
         compare("send_kind", 32'(want.send_kind), 32'(got.send_kind));
         compare("send_seq", 32'(want.send_seq), 32'(got.send_seq));
         compare("local_mux", 32'(want.local_mux), 32'(got.local_mux));
         compare("stage_now", 32'(want.stage_now), 32'(got.stage_now));
         compare("completed_pulse", 32'(want.completed_pulse), 32'(got.completed_pulse));
         compare("failed_pulse", 32'(want.failed_pulse), 32'(got.failed_pulse));
         compare("alive", 32'(want.alive), 32'(got.alive));
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [OP_BITS-1:0]       req_op;
   logic [TIME_BITS-1:0]     req_now;
   logic [SEQ_BITS-1:0]      req_seq_idx;
   logic [MUX_BITS-1:0]      req_new_local_mux;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_send_valid;
   logic                     rsp_send_kind;
   logic [SEQ_BITS-1:0]      rsp_send_seq;
   logic [MUX_BITS-1:0]      rsp_local_mux;
   logic [STAGE_BITS-1:0]    rsp_stage_now;
   logic                     rsp_completed_pulse;
   logic                     rsp_failed_pulse;
   logic                     rsp_alive;
   logic                     csr_write_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   handshake_tracker sb = new();

   // running time base for well-formed sessions
   logic [TIME_BITS-1:0] tick;
   // sender burst bookkeeping
   int                   burst_left;
   // bumped by the main sequence to ask the receiver for one long hold-off
   int                   hold_requests;

   active_connection_handshake_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_now             (req_now),
      .req_seq_idx         (req_seq_idx),
      .req_new_local_mux   (req_new_local_mux),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_send_valid      (rsp_send_valid),
      .rsp_send_kind       (rsp_send_kind),
      .rsp_send_seq        (rsp_send_seq),
      .rsp_local_mux       (rsp_local_mux),
      .rsp_stage_now       (rsp_stage_now),
      .rsp_completed_pulse (rsp_completed_pulse),
      .rsp_failed_pulse    (rsp_failed_pulse),
      .rsp_alive           (rsp_alive),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // offer one request from a falling edge, hold it until taken, then note it
   task automatic send_request(logic [OP_BITS-1:0] op, logic [TIME_BITS-1:0] now,
                               logic [SEQ_BITS-1:0] seq, logic [MUX_BITS-1:0] mux);
      req_valid         <= 1'b1;
      req_op            <= op;
      req_now           <= now;
      req_seq_idx       <= seq;
      req_new_local_mux <= mux;
      do
         @(posedge clock);
      while (req_stall);
      sb.note_request(op, now, seq, mux);
      @(negedge clock);
   endtask

   task automatic idle_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // bursts of back-to-back requests separated by random gaps
   task automatic pace_sender();
      if (burst_left == 0) begin
         idle_sender($urandom_range(1, 6));
         if ($urandom_range(0, 4) == 0)
            burst_left = $urandom_range(30, 80);
         else
            burst_left = $urandom_range(1, 10);
      end
      burst_left--;
   endtask

   // register write while the block is idle
   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      sb.set_reg(idx, data);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // stop offering and wait for every outstanding response
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // one request built from the tracked state, mostly well-formed
   task automatic send_random();
      logic [OP_BITS-1:0]   op;
      logic [TIME_BITS-1:0] now;
      logic [SEQ_BITS-1:0]  seq;
      logic [MUX_BITS-1:0]  mux;
      int                   pick;
      op   = OP_BITS'($urandom_range(0, 7));
      now  = $urandom;
      seq  = SEQ_BITS'($urandom);
      mux  = MUX_BITS'($urandom);
      pick = $urandom_range(0, 99);
      // no live session: usually open a new one
      if ((sb.cur_stage == STAGE_IDLE || sb.cur_stage == STAGE_FAILED ||
           sb.cur_stage == STAGE_FINISHED) && $urandom_range(0, 1))
         pick = 0;
      if (pick < 6) begin
         op = OP_START;
         case ($urandom_range(0, 3))
            0: now = $urandom_range(0, 5000);
            1: now = $urandom;
            2: now = 32'hFFFF_FFFF - $urandom_range(0, 600);
            default: now = tick;
         endcase
         if ($urandom_range(0, 7) == 0)
            mux = '0;
         if ($urandom_range(0, 7) == 0)
            seq = 16'hFFFF - SEQ_BITS'($urandom_range(0, 5));
         tick = now;
      end else if (pick < 50) begin
         op = OP_POLL;
         // step forward, or land on and just past each deadline
         case ($urandom_range(0, 9))
            0: now = tick;
            1, 2, 3, 4: now = tick + $urandom_range(1, 64);
            5: now = sb.retry_dl;
            6: now = sb.retry_dl + 32'd1;
            7: now = sb.total_dl;
            8: now = sb.total_dl + 32'd1;
            default: now = $urandom;
         endcase
         tick = now;
      end else if (pick < 62) begin
         op = OP_PEER_ACK;
         case ($urandom_range(0, 4))
            0, 1: seq = sb.cur_seq;
            2: seq = sb.cur_seq + SEQ_BITS'($urandom_range(1, 3));
            3: seq = sb.cur_seq - 16'd1;
            default: ;
         endcase
      end else if (pick < 74) begin
         op = OP_RETRY;
         if ($urandom_range(0, 5) != 0)
            seq = sb.cur_seq;
         if ($urandom_range(0, 6) == 0)
            mux = '0;
         else
            mux = MUX_BITS'($urandom_range(1, 65535));
      end else if (pick < 80) begin
         op = OP_REFUSED;
         if ($urandom_range(0, 3) != 0)
            seq = sb.cur_seq;
      end else if (pick < 83)
         op = OP_DATAGRAM;
      else if (pick < 87)
         op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
      pace_sender();
      send_request(op, now, seq, mux);
   endtask

   // register settings for each random phase, extremes included
   task automatic apply_phase(int phase);
      case (phase)
         1: begin
            write_csr(CSR_TOTAL_TIMEOUT, 32'd300);
            write_csr(CSR_RETRY_TIMEOUT, 32'd25);
            write_csr(CSR_MAX_TRIES, 32'd3);
         end
         2: begin
            write_csr(CSR_MAX_TRIES, 32'd0);
            write_csr(CSR_TOTAL_TIMEOUT, 32'd0);
            write_csr(CSR_RETRY_TIMEOUT, 32'd0);
         end
         3: begin
            write_csr(CSR_RETRY_TIMEOUT, 32'hFFFF_FFFF);
            write_csr(CSR_TOTAL_TIMEOUT, 32'hFFFF_FFFF);
            write_csr(CSR_MAX_TRIES, 32'd254);
         end
         4: begin
            write_csr(CSR_TOTAL_TIMEOUT, 32'd1000);
            write_csr(CSR_RETRY_TIMEOUT, 32'd7);
            write_csr(CSR_MAX_TRIES, 32'd1);
         end
         default: begin
            write_csr(CSR_TOTAL_TIMEOUT, 32'd60);
            write_csr(CSR_RETRY_TIMEOUT, 32'd3);
            write_csr(CSR_MAX_TRIES, 32'd8);
         end
      endcase
   endtask

   // every accepted response is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response('{rsp_send_valid, rsp_send_kind, rsp_send_seq, rsp_local_mux,
                             rsp_stage_now, rsp_completed_pulse, rsp_failed_pulse,
                             rsp_alive});
   end

   // response side: stall patterns that change every so often, plus one long hold
   initial begin
      int mode;
      int mode_left;
      int cycle;
      int holds_done;
      mode       = 0;
      mode_left  = 0;
      cycle      = 0;
      holds_done = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         if (hold_requests != holds_done) begin
            // hold off long enough for the queue to fill and req_stall to rise
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 120);
         end
         mode_left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((cycle % 5) < 2);
         endcase
      end
   end

   // main sequence
   initial begin
      int phase;
      int n;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_op            <= OP_POLL;
      req_now           <= '0;
      req_seq_idx       <= '0;
      req_new_local_mux <= '0;
      csr_write_en      <= 1'b0;
      csr_index         <= CSR_TOTAL_TIMEOUT;
      csr_wdata         <= '0;
      tick              = '0;
      burst_left        = 0;
      hold_requests     = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part under reset register values
      // idle ignores everything but start
      send_request(OP_POLL, 32'd5, 16'd0, 16'd0);
      send_request(OP_PEER_ACK, 32'd0, 16'hFFFF, 16'd0);
      // start near the sequence wrap, poll sends INIT
      send_request(OP_START, 32'd100, 16'hFFFE, 16'hFFFF);
      send_request(OP_POLL, 32'd100, 16'd0, 16'd0);
      // retry deadline reached but not passed, then passed: sequence wraps to 1
      send_request(OP_POLL, 32'd1100, 16'd0, 16'd0);
      send_request(OP_POLL, 32'd1101, 16'd0, 16'd0);
      send_request(OP_POLL, 32'd1101, 16'd0, 16'd0);
      // refused with another sequence is ignored
      send_request(OP_REFUSED, 32'd0, 16'd2, 16'd0);
      // retry request takes the new mux and advances the sequence
      send_request(OP_RETRY, 32'd0, 16'd1, 16'h1234);
      // peer ack while not waiting is ignored
      send_request(OP_PEER_ACK, 32'd0, 16'd4, 16'd0);
      send_request(OP_POLL, 32'd1200, 16'd0, 16'd0);
      // peer ack below the sequence ignored, above it completes
      send_request(OP_PEER_ACK, 32'd0, 16'd3, 16'd0);
      send_request(OP_PEER_ACK, 32'd0, 16'hFFFF, 16'd0);
      // repeated peer ack resends ACK without a pulse
      send_request(OP_PEER_ACK, 32'd0, 16'd4, 16'd0);
      // overall deadline: equal does not expire, one past finishes a completed handshake
      send_request(OP_POLL, 32'd10100, 16'd0, 16'd0);
      send_request(OP_POLL, 32'd10101, 16'd0, 16'd0);
      // deadlines saturate at the top of the time range
      send_request(OP_START, 32'hFFFF_F000, 16'd0, 16'd0);
      send_request(OP_POLL, 32'hFFFF_FFFF, 16'd0, 16'd0);
      // retry request with zero mux fails
      send_request(OP_RETRY, 32'd0, 16'd0, 16'd0);
      // unused op codes
      send_request(OP_UNUSED_6, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_UNUSED_7, 32'd0, 16'd0, 16'd0);
      // refused outside the waiting stage is ignored, any datagram finishes
      send_request(OP_START, 32'd0, 16'd5, 16'd1);
      send_request(OP_REFUSED, 32'd0, 16'd5, 16'd0);
      send_request(OP_POLL, 32'd0, 16'd0, 16'd0);
      send_request(OP_DATAGRAM, 32'd0, 16'd0, 16'd0);

      // random part, first under reset values, then one phase per setting
      for (n = 0; n < 250; n++)
         send_random();
      for (phase = 1; phase <= 5; phase++) begin
         drain();
         apply_phase(phase);
         if (phase == 1)
            hold_requests++;
         for (n = 0; n < 210; n++)
            send_random();
      end

      drain();
      if (sb.errors == 0)
         $display("active_connection_handshake_top regression: pass");
      else
         $display("active_connection_handshake_top regression: fail");
      $finish;
   end

   // hard stop if the block hangs
   initial begin
      #5_000_000;
      $display("active_connection_handshake_top regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ach_pkg.sv
design/ach_front.sv
design/ach_queue.sv
design/ach_back.sv
design/active_connection_handshake_top.sv
bench/testbench.sv
